FILE: rtl/stretched_exponential_decay_core_macros.svh
// Assertion helpers for the damping core checks.
`ifndef STRETCHED_EXPONENTIAL_DECAY_CORE_MACROS_SVH
`define STRETCHED_EXPONENTIAL_DECAY_CORE_MACROS_SVH

// Clocked check, off while reset is low.
`define SED_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("damping core check failed");

// Clocked check, active in and out of reset.
`define SED_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("damping core check failed");

`endif

FILE: rtl/sed_pkg.sv
package sed_pkg;

  localparam int FR                = 30;
  localparam int OUT_FRAC_BITS_DEF = 16;

  localparam int GAMMA_W    = 32;
  localparam int BETA_W     = 16;
  localparam int WEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRETCH    = 2'd1;

  localparam logic [GAMMA_W-1:0] DECAY_RATE_RST = 32'd16777;
  localparam logic [BETA_W-1:0]  STRETCH_RST    = 16'd4096;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [24:0] LOG2E_Q24 = 25'd24204406;

  localparam int E2F_TERMS   = 24;
  localparam int E2F_LATENCY = 1 + 2 * E2F_TERMS;
  // x, encode, normalize, squarings, beta product, split, two exp2 units,
  // y, z, round, shift
  localparam int SED_LATENCY = 3 + FR + 2 + 2 * E2F_LATENCY + 4;

  localparam int TI_W = 12;
  localparam int ZI_W = 9;

  typedef logic [1:0] frc_t;
  localparam frc_t FRC_NONE = 2'd0;
  localparam frc_t FRC_ONE  = 2'd1;
  localparam frc_t FRC_ZERO = 2'd2;

  typedef struct packed {
    frc_t                   frc;
    logic                   y_one;
    logic signed [TI_W-1:0] ti;
  } e1_side_t;

  typedef struct packed {
    frc_t            frc;
    logic            zf_zero;
    logic [ZI_W-1:0] zi;
  } e2_side_t;

endpackage

FILE: rtl/sed_exp2frac.sv
module sed_exp2frac import sed_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [FR-1:0]     in_frac,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [FR:0]       out_val,
  output logic [SIDE_W-1:0] out_side
);

  localparam int TW   = FR + 1;
  localparam int SUMW = FR + 3;

  logic              b_vld_r  [0:E2F_TERMS];
  logic [TW-1:0]     b_term_r [0:E2F_TERMS];
  logic [SUMW-1:0]   b_sum_r  [0:E2F_TERMS];
  logic [FR-1:0]     b_u_r    [0:E2F_TERMS];
  logic [SIDE_W-1:0] b_side_r [0:E2F_TERMS];

  logic              a_vld_r  [1:E2F_TERMS];
  logic [TW-1:0]     a_n_r    [1:E2F_TERMS];
  logic [SUMW-1:0]   a_sum_r  [1:E2F_TERMS];
  logic [FR-1:0]     a_u_r    [1:E2F_TERMS];
  logic [SIDE_W-1:0] a_side_r [1:E2F_TERMS];

  // u = f * ln2, rounded
  logic [FR+31:0] uprod;
  logic [FR+32:0] usum;
  assign uprod = FR'(in_frac) * LN2_Q32;
  assign usum  = {1'b0, uprod} + (FR+33)'(64'd1 << 31);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r[0] <= 1'b0;
    end else begin
      b_vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_u_r[0]    <= usum[FR+31:32];
    b_term_r[0] <= TW'(1) << FR;
    b_sum_r[0]  <= SUMW'(1) << FR;
    b_side_r[0] <= in_side;
  end

  for (genvar k = 1; k <= E2F_TERMS; k++) begin : g_term
    localparam int          K      = k;
    localparam int          SH     = TW + $clog2(K);
    localparam logic [63:0] RECIP  = ((64'd1 << SH) + 64'(K) - 64'd1) / 64'(K);

    logic [TW+FR-1:0] mprod;
    logic [TW+FR:0]   mrnd;
    logic [TW+SH:0]   dprod;

    assign mprod = (TW+FR)'(b_term_r[k-1]) * (TW+FR)'(b_u_r[k-1]);
    assign mrnd  = {1'b0, mprod} + (TW+FR+1)'(64'd1 << (FR-1));
    assign dprod = (TW+SH+1)'(a_n_r[k]) * (TW+SH+1)'(RECIP);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_vld_r[k] <= 1'b0;
        b_vld_r[k] <= 1'b0;
      end else begin
        a_vld_r[k] <= b_vld_r[k-1];
        b_vld_r[k] <= a_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      a_n_r[k]    <= mrnd[TW+FR-1:FR];
      a_sum_r[k]  <= b_sum_r[k-1];
      a_u_r[k]    <= b_u_r[k-1];
      a_side_r[k] <= b_side_r[k-1];
      b_term_r[k] <= dprod[SH+TW-1:SH];
      b_sum_r[k]  <= a_sum_r[k] + SUMW'(dprod[SH+TW-1:SH]);
      b_u_r[k]    <= a_u_r[k];
      b_side_r[k] <= a_side_r[k];
    end
  end

  localparam logic [SUMW-1:0] SUM_CAP = (SUMW'(1) << TW) - SUMW'(1);

  assign out_vld  = b_vld_r[E2F_TERMS];
  assign out_side = b_side_r[E2F_TERMS];
  assign out_val  = (b_sum_r[E2F_TERMS] > SUM_CAP) ? SUM_CAP[TW-1:0]
                                                   : b_sum_r[E2F_TERMS][TW-1:0];

endmodule

FILE: rtl/stretched_exponential_decay_core.sv
// Stretched-exponential damping core: for each weight w it returns
// exp(-(gamma*w)^beta) as an unsigned Q1.OUT_FRAC_BITS fraction clamped to
// [0, 1.0]. start is taken in every cycle (busy stays low) and each beat
// leaves on out_valid at the end of the pipeline, one result per cycle; the
// receiver cannot stall and out_valid lasts one cycle. The pipeline holds
// the 30 squaring stages of the log2 and the two 49-stage exp2 series units.
// gamma (index 0) and beta (index 1) may be written only while no beat is
// in flight; cfg_ready is always high.
module stretched_exponential_decay_core import sed_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [WEIGHT_W-1:0]   in_term_weight,
  output logic                  out_valid,
  output logic [OUT_FRAC_BITS:0] out_damping,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW  = GAMMA_W + WEIGHT_W;
  localparam int PW  = $clog2(XW);
  localparam int MW  = FR + 1;
  localparam int LW  = 7 + FR;
  localparam int TFW = LW + BETA_W + 1;
  localparam int YW  = FR + 8;
  localparam int VW  = 32 + OUT_FRAC_BITS;
  localparam int SW  = $clog2(VW);
  localparam int S_W = ZI_W + 1;
  localparam logic [OUT_FRAC_BITS:0] DAMP_ONE = {1'b1, {OUT_FRAC_BITS{1'b0}}};

  logic [GAMMA_W-1:0] decay_rate_r;
  logic [BETA_W-1:0]  stretch_exponent_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_rate_r       <= DECAY_RATE_RST;
      stretch_exponent_r <= STRETCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DECAY_RATE: decay_rate_r       <= cfg_data[GAMMA_W-1:0];
        CFG_STRETCH:    stretch_exponent_r <= cfg_data[BETA_W-1:0];
        default: ;
      endcase
    end
  end

  // x = gamma * w
  logic          x_vld_r;
  logic [XW-1:0] x_r;

  // leading one
  logic          p_vld_r;
  logic [XW-1:0] p_x_r;
  logic [PW-1:0] p_r;
  logic [PW-1:0] p_nxt;

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < XW; i++) begin
      if (x_r[i]) p_nxt = PW'(i);
    end
  end

  // normalized mantissa and log2 squaring chain
  logic          sq_vld_r  [0:FR];
  logic [MW-1:0] sq_m_r    [0:FR];
  logic [FR-1:0] sq_frac_r [0:FR];
  logic [PW-1:0] sq_p_r    [0:FR];
  logic          sq_zero_r [0:FR];
  logic [XW-1:0] norm_nxt;

  always_comb begin
    if (p_r >= PW'(FR)) begin
      norm_nxt = p_x_r >> (p_r - PW'(FR));
    end else begin
      norm_nxt = p_x_r << (PW'(FR) - p_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r     <= 1'b0;
      p_vld_r     <= 1'b0;
      sq_vld_r[0] <= 1'b0;
    end else begin
      x_vld_r     <= start && !busy;
      p_vld_r     <= x_vld_r;
      sq_vld_r[0] <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= XW'(decay_rate_r) * XW'(in_term_weight);
    p_x_r        <= x_r;
    p_r          <= p_nxt;
    sq_m_r[0]    <= norm_nxt[MW-1:0];
    sq_frac_r[0] <= '0;
    sq_p_r[0]    <= p_r;
    sq_zero_r[0] <= (p_x_r == '0);
  end

  for (genvar i = 1; i <= FR; i++) begin : g_sq
    logic [2*MW-1:0] prod;
    logic [MW:0]     q;

    assign prod = (2*MW)'(sq_m_r[i-1]) * (2*MW)'(sq_m_r[i-1]);
    assign q    = prod[2*MW-1:FR];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[i] <= 1'b0;
      end else begin
        sq_vld_r[i] <= sq_vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      sq_m_r[i]    <= q[MW] ? q[MW:1] : q[MW-1:0];
      sq_frac_r[i] <= sq_frac_r[i-1] | (FR'(q[MW]) << (FR - i));
      sq_p_r[i]    <= sq_p_r[i-1];
      sq_zero_r[i] <= sq_zero_r[i-1];
    end
  end

  // t = log2(x) * beta
  logic signed [6:0]     pe;
  logic signed [LW-1:0]  lg;
  logic signed [BETA_W:0] beta_s;
  logic signed [TFW-1:0] tprod;

  assign pe     = $signed({1'b0, sq_p_r[FR]}) - 7'sd24;
  assign lg     = $signed({pe, sq_frac_r[FR]});
  assign beta_s = $signed({1'b0, stretch_exponent_r});
  assign tprod  = lg * beta_s;

  logic                  t_vld_r;
  logic signed [TFW-1:0] t_full_r;
  logic                  t_zero_r;
  logic                  t_beta0_r;

  // split into integer and fraction, floored to 30 fraction bits
  logic signed [TI_W-1:0] ti;
  e1_side_t               e1_side_nxt;

  assign ti = t_full_r[TFW-1:TFW-TI_W];

  always_comb begin
    e1_side_nxt.ti    = ti;
    e1_side_nxt.y_one = t_beta0_r;
    if (t_beta0_r) begin
      e1_side_nxt.frc = FRC_NONE;
    end else if (t_zero_r) begin
      e1_side_nxt.frc = FRC_ONE;
    end else if (ti >= 12'sd8) begin
      e1_side_nxt.frc = FRC_ZERO;
    end else begin
      e1_side_nxt.frc = FRC_NONE;
    end
  end

  logic          e1_in_vld_r;
  logic [FR-1:0] e1_in_frac_r;
  e1_side_t      e1_in_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r     <= 1'b0;
      e1_in_vld_r <= 1'b0;
    end else begin
      t_vld_r     <= sq_vld_r[FR];
      e1_in_vld_r <= t_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    t_full_r     <= tprod;
    t_zero_r     <= sq_zero_r[FR];
    t_beta0_r    <= (stretch_exponent_r == '0);
    e1_in_frac_r <= t_full_r[FR+11:12];
    e1_in_side_r <= e1_side_nxt;
  end

  logic                       e1_out_vld;
  logic [FR:0]                e1_out_val;
  logic [$bits(e1_side_t)-1:0] e1_out_side;
  e1_side_t                   e1_side;

  sed_exp2frac #(
    .SIDE_W ($bits(e1_side_t))
  ) u_exp2_pow (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (e1_in_vld_r),
    .in_frac  (e1_in_frac_r),
    .in_side  (e1_in_side_r),
    .out_vld  (e1_out_vld),
    .out_val  (e1_out_val),
    .out_side (e1_out_side)
  );

  assign e1_side = e1_side_t'(e1_out_side);

  // y = 2^t
  logic [TI_W-1:0] neg_ti;
  logic [YW-1:0]   y_nxt;

  assign neg_ti = TI_W'(0) - TI_W'(e1_side.ti);

  always_comb begin
    if (e1_side.y_one) begin
      y_nxt = YW'(1) << FR;
    end else if (e1_side.ti >= 12'sd0) begin
      y_nxt = YW'(e1_out_val) << e1_side.ti[2:0];
    end else if (neg_ti >= TI_W'(MW)) begin
      y_nxt = '0;
    end else begin
      y_nxt = YW'(e1_out_val) >> neg_ti[4:0];
    end
  end

  logic          y_vld_r;
  logic [YW-1:0] y_r;
  frc_t          y_frc_r;

  // z = y * log2(e), rounded
  logic [63:0] zfull;
  logic [FR+ZI_W-1:0] z;
  e2_side_t    e2_side_nxt;

  assign zfull = 64'(y_r) * 64'(LOG2E_Q24) + (64'd1 << 23);
  assign z     = zfull[FR+ZI_W+23:24];

  always_comb begin
    e2_side_nxt.frc     = y_frc_r;
    e2_side_nxt.zf_zero = (z[FR-1:0] == '0);
    e2_side_nxt.zi      = z[FR+ZI_W-1:FR];
  end

  logic          e2_in_vld_r;
  logic [FR-1:0] e2_in_frac_r;
  e2_side_t      e2_in_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_vld_r     <= 1'b0;
      e2_in_vld_r <= 1'b0;
    end else begin
      y_vld_r     <= e1_out_vld;
      e2_in_vld_r <= y_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    y_r          <= y_nxt;
    y_frc_r      <= e1_side.frc;
    e2_in_frac_r <= FR'(0) - z[FR-1:0];
    e2_in_side_r <= e2_side_nxt;
  end

  logic                       e2_out_vld;
  logic [FR:0]                e2_out_val;
  logic [$bits(e2_side_t)-1:0] e2_out_side;
  e2_side_t                   e2_side;

  sed_exp2frac #(
    .SIDE_W ($bits(e2_side_t))
  ) u_exp2_neg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (e2_in_vld_r),
    .in_frac  (e2_in_frac_r),
    .in_side  (e2_in_side_r),
    .out_vld  (e2_out_vld),
    .out_val  (e2_out_val),
    .out_side (e2_out_side)
  );

  assign e2_side = e2_side_t'(e2_out_side);

  // 2^-z: scale to output bits with round half up
  logic [FR:0]   v;
  logic [S_W-1:0] s;
  logic [S_W-1:0] sm1;
  logic          s_big;
  logic [VW-1:0] rsum_nxt;

  assign v     = e2_side.zf_zero ? (MW'(1) << FR) : e2_out_val;
  assign s     = S_W'(e2_side.zi) + (e2_side.zf_zero ? S_W'(FR) : S_W'(FR + 1));
  assign sm1   = s - S_W'(1);
  assign s_big = (s > S_W'(31 + OUT_FRAC_BITS));
  assign rsum_nxt = (VW'(v) << OUT_FRAC_BITS) + (VW'(1) << sm1[SW-1:0]);

  logic          f1_vld_r;
  logic [VW-1:0] f1_sum_r;
  logic [SW-1:0] f1_sh_r;
  logic          f1_zero_r;
  logic          f1_one_r;

  logic [VW-1:0]          r_full;
  logic [OUT_FRAC_BITS:0] damp_nxt;

  assign r_full = f1_sum_r >> f1_sh_r;

  always_comb begin
    if (f1_one_r) begin
      damp_nxt = DAMP_ONE;
    end else if (f1_zero_r) begin
      damp_nxt = '0;
    end else if (r_full > VW'(DAMP_ONE)) begin
      damp_nxt = DAMP_ONE;
    end else begin
      damp_nxt = r_full[OUT_FRAC_BITS:0];
    end
  end

  logic                   out_valid_r;
  logic [OUT_FRAC_BITS:0] out_damping_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      f1_vld_r    <= e2_out_vld;
      out_valid_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_sum_r      <= rsum_nxt;
    f1_sh_r       <= s[SW-1:0];
    f1_zero_r     <= s_big || (e2_side.frc == FRC_ZERO);
    f1_one_r      <= (e2_side.frc == FRC_ONE);
    out_damping_r <= damp_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_damping = out_damping_r;

endmodule

FILE: rtl/sed_checker.sv
`include "stretched_exponential_decay_core_macros.svh"

module sed_checker import sed_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_valid,
  input logic [OUT_FRAC_BITS:0] out_damping
);

  localparam logic [OUT_FRAC_BITS:0] DAMP_ONE = {1'b1, {OUT_FRAC_BITS{1'b0}}};

  `SED_ASSERT(a_lat_fwd, clk, rst_n, (start && !busy) |-> ##SED_LATENCY out_valid)
  `SED_ASSERT(a_lat_bwd, clk, rst_n, out_valid |-> $past(start && !busy, SED_LATENCY))
  `SED_ASSERT(a_range, clk, rst_n, out_valid |-> (out_damping <= DAMP_ONE))
  `SED_ASSERT_ALWAYS(a_no_stall, clk, !busy)

endmodule

bind stretched_exponential_decay_core sed_checker #(
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_sed_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_damping (out_damping)
);
